/* hdl/assert_macros.svh */
// assertion helpers used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// implication checked on every rising clock edge outside reset
`define CRM_ASSERT_IMP(label, clk, rst_n, a, c) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
        else $error("assertion failed");
// next-cycle implication checked outside reset
`define CRM_ASSERT_NXT(label, clk, rst_n, a, c) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
        else $error("assertion failed");
`endif

/* hdl/crm_pkg.sv */
// ----------------------------------------------------------------------------
// crm_pkg
// shared constants and types of the conv, relu and max-pool layer
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
package crm_pkg;
    localparam int MAX_IN_CHANNELS_D  = 64;
    localparam int MAX_OUT_CHANNELS_D = 128;
    localparam int MAX_SIDE_D         = 32;
    localparam int MAX_KERNEL_D       = 3;

    localparam logic [1:0] KIND_PIXEL  = 2'd0;
    localparam logic [1:0] KIND_WEIGHT = 2'd1;
    localparam logic [1:0] KIND_BIAS   = 2'd2;
    localparam logic [1:0] KIND_CALC   = 2'd3;

    localparam logic [2:0] REG_IN_CH  = 3'd0;
    localparam logic [2:0] REG_OUT_CH = 3'd1;
    localparam logic [2:0] REG_KSIDE  = 3'd2;
    localparam logic [2:0] REG_CSTEP  = 3'd3;
    localparam logic [2:0] REG_BORDER = 3'd4;
    localparam logic [2:0] REG_PSIDE  = 3'd5;
    localparam logic [2:0] REG_PSTEP  = 3'd6;

    localparam int CFG_W = 8;
endpackage
`default_nettype wire

/* hdl/crm_ram.sv */
// ----------------------------------------------------------------------------
// crm_ram
// single port write, single port registered read memory
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module crm_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire

/* hdl/conv_relu_maxpool_layer.sv */
// ----------------------------------------------------------------------------
// conv_relu_maxpool_layer
// convolution, relu and max-pool, one pooled output per compute beat
// ----------------------------------------------------------------------------
// usage:
//   input beats carry a kind: pixel, weight and bias beats write the stores
//   and return nothing; a compute beat returns one result beat.
//   configuration registers are written by i_cfg_we; write them only while
//   the block is idle, as the block does not enforce it. a compute beat
//   walks the pool window, input channels and kernel taps through one
//   shared multiply-accumulate, each tap through the address, memory read
//   and multiply-accumulate states and each window position through a
//   window and a position state; a bad position answers after the size
//   states. the block does not accept a beat while it computes or while a
//   result waits on the output register, and takes the next beat in the
//   cycle after the result beat leaves. padding taps pass the same states
//   but add nothing. a stalled result holds. reset returns configuration
//   registers and state to their defaults; stores are not cleared. the
//   winner index is built in the idx states after the window.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module conv_relu_maxpool_layer
    import crm_pkg::*;
#(
    parameter int MAX_IN_CHANNELS  = MAX_IN_CHANNELS_D,
    parameter int MAX_OUT_CHANNELS = MAX_OUT_CHANNELS_D,
    parameter int MAX_SIDE         = MAX_SIDE_D,
    parameter int MAX_KERNEL       = MAX_KERNEL_D
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_cfg_we,
    input  wire logic [2:0]         i_cfg_index,
    input  wire logic [CFG_W-1:0]   i_cfg_data,
    input  wire logic               i_valid,
    output logic                    o_stall,
    input  wire logic [1:0]         i_kind,
    input  wire logic [6:0]         i_channel,
    input  wire logic [5:0]         i_source_channel,
    input  wire logic [4:0]         i_row,
    input  wire logic [4:0]         i_col,
    input  wire logic signed [15:0] i_value,
    input  wire logic [5:0]         i_image_height,
    input  wire logic [5:0]         i_image_width,
    input  wire logic [15:0]        i_image_number,
    output logic                    o_valid,
    input  wire logic               i_stall,
    output logic [14:0]             o_pooled_value,
    output logic [33:0]             o_winner_index,
    output logic                    o_bad_position
);
    localparam int CW = $clog2(MAX_IN_CHANNELS) > 0 ? $clog2(MAX_IN_CHANNELS) : 1;
    localparam int OW = $clog2(MAX_OUT_CHANNELS) > 0 ? $clog2(MAX_OUT_CHANNELS) : 1;
    localparam int KK = MAX_KERNEL * MAX_KERNEL;
    localparam int FD = MAX_IN_CHANNELS * MAX_SIDE * MAX_SIDE;
    localparam int WD = MAX_OUT_CHANNELS * MAX_IN_CHANNELS * KK;
    localparam int FA = $clog2(FD);
    localparam int WA = $clog2(WD);
    localparam int BA = OW;
    localparam int KW = $clog2(MAX_KERNEL + 1);
    localparam int OCL = MAX_OUT_CHANNELS < 128 ? MAX_OUT_CHANNELS : 128;
    localparam int ICL = MAX_IN_CHANNELS < 64 ? MAX_IN_CHANNELS : 64;
    localparam int KL  = MAX_KERNEL < 3 ? MAX_KERNEL : 3;

    typedef enum logic [3:0] {
        S_IDLE, S_SIZE, S_SIZE2, S_WIN, S_ADDR, S_READ, S_MAC, S_POS, S_IDX1, S_IDX2,
        S_IDX3, S_DONE, S_OUT
    } t_state;

    // configuration
    logic [6:0] r_ic;
    logic [7:0] r_oc;
    logic [1:0] r_k;
    logic [2:0] r_cs, r_ps, r_pp;
    logic [1:0] r_pb;

    function automatic logic [7:0] clamp8(input logic [7:0] v, input int lo, input int hi);
        logic [7:0] res;
        res = v;
        if (int'(v) < lo) res = 8'(lo);
        if (int'(v) > hi) res = 8'(hi);
        return res;
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ic <= 7'(ICL < 3 ? ICL : 3);
            r_oc <= 8'(OCL < 32 ? OCL : 32);
            r_k  <= 2'(KL);
            r_cs <= 3'd1;
            r_pb <= 2'd1;
            r_ps <= 3'd2;
            r_pp <= 3'd2;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                REG_IN_CH:  r_ic <= 7'(clamp8({1'b0, i_cfg_data[6:0]}, 1, ICL));
                REG_OUT_CH: r_oc <= clamp8(i_cfg_data, 1, OCL);
                REG_KSIDE:  r_k  <= 2'(clamp8({6'd0, i_cfg_data[1:0]}, 1, KL));
                REG_CSTEP:  r_cs <= 3'(clamp8({5'd0, i_cfg_data[2:0]}, 1, 4));
                REG_BORDER: r_pb <= 2'(clamp8({6'd0, i_cfg_data[1:0]}, 0, 2));
                REG_PSIDE:  r_ps <= 3'(clamp8({5'd0, i_cfg_data[2:0]}, 1, 4));
                REG_PSTEP:  r_pp <= 3'(clamp8({5'd0, i_cfg_data[2:0]}, 1, 4));
                default: ;
            endcase
        end
    end

    // stores
    logic          in_acc;
    logic [FA-1:0] r_fa;
    logic [WA-1:0] r_wa;
    logic [BA-1:0] r_ba;
    logic [15:0]   f_rd, w_rd, b_rd;
    logic          f_we, w_we, b_we;
    logic [FA-1:0] f_wa;
    logic [WA-1:0] w_wa;

    assign in_acc = i_valid && !o_stall;
    assign f_we = in_acc && i_kind == KIND_PIXEL && 32'(i_channel) < MAX_IN_CHANNELS
                  && 32'(i_row) < MAX_SIDE && 32'(i_col) < MAX_SIDE;
    assign w_we = in_acc && i_kind == KIND_WEIGHT && 32'(i_channel) < MAX_OUT_CHANNELS
                  && 32'(i_source_channel) < MAX_IN_CHANNELS
                  && 32'(i_row) < MAX_KERNEL && 32'(i_col) < MAX_KERNEL;
    assign b_we = in_acc && i_kind == KIND_BIAS && 32'(i_channel) < MAX_OUT_CHANNELS;
    assign f_wa = FA'(((32'(i_channel) * MAX_SIDE + 32'(i_row)) * MAX_SIDE) + 32'(i_col));
    assign w_wa = WA'(((32'(i_channel) * MAX_IN_CHANNELS + 32'(i_source_channel))
                       * MAX_KERNEL + 32'(i_row)) * MAX_KERNEL + 32'(i_col));

    crm_ram #(.WIDTH(16), .DEPTH(FD)) u_feat (
        .i_clk(i_clk), .i_we(f_we), .i_waddr(f_wa), .i_wdata(i_value),
        .i_raddr(r_fa), .o_rdata(f_rd));
    crm_ram #(.WIDTH(16), .DEPTH(WD)) u_wgt (
        .i_clk(i_clk), .i_we(w_we), .i_waddr(w_wa), .i_wdata(i_value),
        .i_raddr(r_wa), .o_rdata(w_rd));
    crm_ram #(.WIDTH(16), .DEPTH(MAX_OUT_CHANNELS)) u_bias (
        .i_clk(i_clk), .i_we(b_we), .i_waddr(BA'(i_channel)), .i_wdata(i_value),
        .i_raddr(r_ba), .o_rdata(b_rd));

    // compute state
    t_state r_st;
    logic [OW-1:0] r_ch;
    logic [4:0]  r_pr, r_pc;
    logic [5:0]  r_h, r_w;
    logic [15:0] r_img;
    logic [6:0]  r_chv, r_cwv;   // conv sizes, up to 36
    logic [2:0]  r_pi, r_pj;
    logic [CW-1:0] r_icn;
    logic [KW-1:0] r_kh, r_kw;
    logic [7:0]  r_yh, r_yw;
    logic signed [47:0] r_acc, r_best;
    logic        r_have, r_bad;
    logic [33:0] r_widx, r_t;
    logic        r_tapok;
    logic signed [31:0] r_prod;

    // the shared multiplier works on the registered store outputs
    logic signed [31:0] mac_prod;
    assign mac_prod = signed'(f_rd) * signed'(w_rd);

    // conv and pool sizes from registered image size; small values, no divider
    logic [7:0] span_h, span_w;
    assign span_h = 8'(r_h) + 8'({r_pb, 1'b0});
    assign span_w = 8'(r_w) + 8'({r_pb, 1'b0});
    function automatic logic [6:0] osz(input logic [7:0] n, input logic [2:0] k,
                                       input logic [2:0] s);
        logic [7:0] d;
        logic [6:0] q;
        q = 7'd0;
        if (n < 8'(k)) return 7'd0;
        d = n - 8'(k);
        case (s)
            3'd1: q = 7'(d);
            3'd2: q = 7'(d >> 1);
            3'd3: q = 7'((16'(d) * 16'd171) >> 9);
            default: q = 7'(d >> 2);
        endcase
        return q + 7'd1;
    endfunction
    logic [6:0] poolh, poolw;
    assign poolh = osz({1'b0, r_chv}, r_ps, r_pp);
    assign poolw = osz({1'b0, r_cwv}, r_ps, r_pp);

    // tap position
    logic signed [9:0] ih, iw;
    assign ih = 10'(16'(r_yh) * 16'(r_cs)) + 10'(r_kh) - 10'(r_pb);
    assign iw = 10'(16'(r_yw) * 16'(r_cs)) + 10'(r_kw) - 10'(r_pb);
    logic tap_in;
    assign tap_in = !ih[9] && !iw[9] && ih < $signed({4'd0, r_h}) && iw < $signed({4'd0, r_w});

    logic last_kw, last_kh, last_ic, last_pj, last_pi;
    assign last_kw = 2'(r_kw) == r_k - 2'd1;
    assign last_kh = 2'(r_kh) == r_k - 2'd1;
    assign last_ic = 7'(r_icn) == r_ic - 7'd1;
    assign last_pj = r_pj == r_ps - 3'd1;
    assign last_pi = r_pi == r_ps - 3'd1;

    logic signed [47:0] relu;
    assign relu = r_acc[47] ? 48'sd0 : r_acc;

    assign o_stall = r_st != S_IDLE;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st    <= S_IDLE;
            o_valid <= 1'b0;
        end else begin
            case (r_st)
                S_IDLE: begin
                    if (in_acc && i_kind == KIND_CALC) begin
                        r_ch  <= OW'(i_channel);
                        r_bad <= {1'b0, i_channel} >= r_oc;
                        r_pr  <= i_row;
                        r_pc  <= i_col;
                        r_h   <= i_image_height == 0 ? 6'd1 :
                                 (32'(i_image_height) > MAX_SIDE ? 6'(MAX_SIDE) : i_image_height);
                        r_w   <= i_image_width == 0 ? 6'd1 :
                                 (32'(i_image_width) > MAX_SIDE ? 6'(MAX_SIDE) : i_image_width);
                        r_img <= i_image_number;
                        r_ba  <= BA'(i_channel);
                        r_st  <= S_SIZE;
                    end
                end
                S_SIZE: begin
                    r_chv <= osz(span_h, {1'b0, r_k}, r_cs);
                    r_cwv <= osz(span_w, {1'b0, r_k}, r_cs);
                    r_st  <= S_SIZE2;
                end
                S_SIZE2: begin
                    if (r_bad || 7'(r_pr) >= poolh || 7'(r_pc) >= poolw) begin
                        o_pooled_value <= 15'd0;
                        o_winner_index <= 34'd0;
                        o_bad_position <= 1'b1;
                        o_valid        <= 1'b1;
                        r_st           <= S_OUT;
                    end else begin
                        r_pi <= 3'd0;
                        r_pj <= 3'd0;
                        r_have <= 1'b0;
                        r_st <= S_WIN;
                    end
                end
                S_WIN: begin
                    r_yh  <= 8'(r_pr) * 8'(r_pp) + 8'(r_pi);
                    r_yw  <= 8'(r_pc) * 8'(r_pp) + 8'(r_pj);
                    r_acc <= 48'(signed'(b_rd)) <<< 12;
                    r_icn <= '0;
                    r_kh  <= '0;
                    r_kw  <= '0;
                    r_st  <= S_ADDR;
                end
                S_ADDR: begin
                    r_tapok <= tap_in;
                    r_fa <= FA'((32'(r_icn) * MAX_SIDE + 32'(ih[7:0])) * MAX_SIDE
                                + 32'(iw[7:0]));
                    r_wa <= WA'(((32'(r_ch) * MAX_IN_CHANNELS + 32'(r_icn)) * MAX_KERNEL
                                 + 32'(r_kh)) * MAX_KERNEL + 32'(r_kw));
                    r_st <= S_READ;
                end
                S_READ: begin
                    // store outputs settle at this edge
                    r_st <= S_MAC;
                end
                S_MAC: begin
                    if (r_tapok) r_acc <= r_acc + 48'(mac_prod);
                    if (last_kw) begin
                        r_kw <= '0;
                        if (last_kh) begin
                            r_kh <= '0;
                            r_icn <= r_icn + 1'b1;
                        end else begin
                            r_kh <= r_kh + 1'b1;
                        end
                    end else begin
                        r_kw <= r_kw + 1'b1;
                    end
                    r_st <= (last_kw && last_kh && last_ic) ? S_POS : S_ADDR;
                end
                S_POS: begin
                    if (!r_have || relu > r_best) begin
                        r_have <= 1'b1;
                        r_best <= relu;
                        // winner index built in the idx states from these
                        r_widx <= {26'd0, r_yh};
                        r_t    <= {26'd0, r_yw};
                    end
                    if (last_pj) begin
                        r_pj <= 3'd0;
                        r_pi <= r_pi + 3'd1;
                    end else begin
                        r_pj <= r_pj + 3'd1;
                    end
                    r_st <= (last_pj && last_pi) ? S_IDX1 : S_WIN;
                end
                S_IDX1: begin
                    // img*oc + ch, then *conv_h
                    r_prod <= 32'(r_img) * 32'(r_oc) + 32'(r_ch);
                    r_st <= S_IDX2;
                end
                S_IDX2: begin
                    r_t <= r_t;
                    r_widx <= 34'(34'(r_prod) * 34'(r_chv)) + r_widx;
                    r_st <= S_IDX3;
                end
                S_IDX3: begin
                    r_widx <= 34'(r_widx * 34'(r_cwv)) + r_t;
                    r_st <= S_DONE;
                end
                S_DONE: begin
                    o_pooled_value <= (|r_best[47:27]) ? 15'h7FFF : r_best[26:12];
                    o_winner_index <= r_widx;
                    o_bad_position <= 1'b0;
                    o_valid <= 1'b1;
                    r_st <= S_OUT;
                end
                S_OUT: begin
                    if (!i_stall) begin
                        o_valid <= 1'b0;
                        r_st <= S_IDLE;
                    end
                end
                default: r_st <= S_IDLE;
            endcase
        end
    end
endmodule
`default_nettype wire

/* hdl/crm_checker.sv */
// ----------------------------------------------------------------------------
// crm_checker
// port level checks of the conv, relu and max-pool layer
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module crm_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        i_valid,
    input wire logic        o_stall,
    input wire logic        o_valid,
    input wire logic        i_stall,
    input wire logic [14:0] o_pooled_value,
    input wire logic [33:0] o_winner_index,
    input wire logic        o_bad_position
);
    // a pending result blocks new input beats
    `CRM_ASSERT_IMP(a_out_blocks, i_clk, i_rst_n, o_valid, o_stall)
    // a bad position reports zero value and index
    `CRM_ASSERT_IMP(a_bad_zero, i_clk, i_rst_n, o_valid && o_bad_position,
        o_pooled_value == 15'd0 && o_winner_index == 34'd0)
    // stalled result holds
    `CRM_ASSERT_NXT(a_hold, i_clk, i_rst_n, o_valid && i_stall,
        o_valid && $stable(o_pooled_value) && $stable(o_winner_index))
    // an accepted beat never meets a result in the same cycle
    `CRM_ASSERT_IMP(a_accept_idle, i_clk, i_rst_n, i_valid && !o_stall, !o_valid)
endmodule

bind conv_relu_maxpool_layer crm_checker u_crm_checker (
    .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .o_stall(o_stall),
    .o_valid(o_valid), .i_stall(i_stall), .o_pooled_value(o_pooled_value),
    .o_winner_index(o_winner_index), .o_bad_position(o_bad_position));
`default_nettype wire
